### sv/lbas_pkg.sv
// ----------------------------------------------------------------------------
// Line boundary access splitter package
// Shared constants and the word types passed between front, queue, back and top.
// ----------------------------------------------------------------------------
package lbas_pkg;

  localparam int ADDR_W          = 64;
  localparam int THREAD_W        = 8;
  localparam int COUNT_W         = 7;
  localparam int SEQ_W           = 32;
  localparam int SIZE_W          = 4;
  localparam int LINE_OFS_W      = 6;
  localparam int LINE_BYTES      = 64;
  localparam int MAX_ACCESS_BYTES = 64;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [THREAD_W-1:0] thread_id;
    logic [ADDR_W-1:0]   address;
    logic [COUNT_W-1:0]  byte_count;
    logic                is_write;
  } access_t;

  typedef struct packed {
    logic [THREAD_W-1:0] thread;
    logic [ADDR_W-1:0]   address;
    logic                write;
    logic [SEQ_W-1:0]    seq;
    logic [SIZE_W-1:0]   bytes;
    logic                last;
  } chunk_t;

endpackage

### sv/lbas_front.sv
// ----------------------------------------------------------------------------
// Line boundary access splitter front
// Accepts access words, clamps the byte count and drops empty accesses.
// ----------------------------------------------------------------------------
module lbas_front (
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [lbas_pkg::THREAD_W-1:0] thread_id,
  input  logic [lbas_pkg::ADDR_W-1:0]   address,
  input  logic [lbas_pkg::COUNT_W-1:0]  byte_count,
  input  logic                    is_write,
  input  logic                    q_ready,
  output logic                    q_push,
  output lbas_pkg::access_t       q_data
);
  import lbas_pkg::*;

  localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_ACCESS_BYTES);

  assign s_axis_tready = q_ready;

  always_comb begin
    q_data.thread_id  = thread_id;
    q_data.address    = address;
    q_data.byte_count = (byte_count > MaxCount) ? MaxCount : byte_count;
    q_data.is_write   = is_write;
  end

  // An access with no bytes is consumed here and never reaches the queue.
  assign q_push = s_axis_tvalid && q_ready && (byte_count != '0);

endmodule

### sv/lbas_queue.sv
// ----------------------------------------------------------------------------
// Line boundary access splitter queue
// Small FIFO of accesses between the front and the back.
// ----------------------------------------------------------------------------
module lbas_queue #(
  parameter int DEPTH = lbas_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lbas_pkg::access_t push_data,
  output logic              ready,
  input  logic              pop,
  output logic              valid,
  output lbas_pkg::access_t pop_data
);
  import lbas_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LastPtr = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FullCnt = CNT_W'(DEPTH);

  access_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  logic do_push;
  logic do_pop;

  assign ready    = (fill != FullCnt);
  assign valid    = (fill != '0);
  assign pop_data = mem[rd_ptr];
  assign do_push  = push && ready;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### sv/lbas_back.sv
// ----------------------------------------------------------------------------
// Line boundary access splitter back
// Walks one access at a time and emits one chunk word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module lbas_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  lbas_pkg::access_t q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output lbas_pkg::chunk_t  out_chunk
);
  import lbas_pkg::*;

  logic                  active;
  logic [THREAD_W-1:0]   cur_thread;
  logic [ADDR_W-1:0]     cur_addr;
  logic [COUNT_W-1:0]    remaining;
  logic                  cur_write;
  logic [SEQ_W-1:0]      chunk_counter;

  logic [LINE_OFS_W:0]   room;
  logic [SIZE_W-1:0]     len;
  logic [COUNT_W-1:0]    remaining_next;
  logic                  emit;

  assign room = (LINE_OFS_W+1)'(LINE_BYTES) - {1'b0, cur_addr[LINE_OFS_W-1:0]};

  always_comb begin
    if (remaining >= COUNT_W'(8) && room >= (LINE_OFS_W+1)'(8)) begin
      len = SIZE_W'(8);
    end else if (remaining >= COUNT_W'(4) && room >= (LINE_OFS_W+1)'(4)) begin
      len = SIZE_W'(4);
    end else if (remaining >= COUNT_W'(2) && room >= (LINE_OFS_W+1)'(2)) begin
      len = SIZE_W'(2);
    end else begin
      len = SIZE_W'(1);
    end
  end

  assign remaining_next = remaining - COUNT_W'(len);
  assign emit  = active && (!out_valid || out_ready);
  assign q_pop = q_valid && !active;

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      out_valid     <= 1'b0;
      chunk_counter <= '0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        active     <= 1'b1;
        cur_thread <= q_data.thread_id;
        cur_addr   <= q_data.address;
        remaining  <= q_data.byte_count;
        cur_write  <= q_data.is_write;
      end else if (emit) begin
        out_valid         <= 1'b1;
        out_chunk.thread  <= cur_thread;
        out_chunk.address <= cur_addr;
        out_chunk.write   <= cur_write;
        out_chunk.seq     <= chunk_counter;
        out_chunk.bytes   <= len;
        out_chunk.last    <= (remaining_next == '0);
        chunk_counter     <= chunk_counter + 1'b1;
        cur_addr          <= cur_addr + ADDR_W'(len);
        remaining         <= remaining_next;
        if (remaining_next == '0) begin
          active <= 1'b0;
        end
      end
    end
  end

endmodule

### sv/line_boundary_access_splitter_top.sv
// ----------------------------------------------------------------------------
// Line boundary access splitter
// Splits byte accesses into 1, 2, 4 or 8 byte chunks inside 64-byte lines.
// ----------------------------------------------------------------------------
// The s_axis channel takes one access word per handshake: thread, start
// address and byte count in tdata, the write flag in tuser. Counts above
// the maximum access size are clamped; a zero count is taken and dropped.
// The m_axis channel returns one word per chunk in address order, with the
// chunk's thread, address, sequence number and size in tdata, the write flag
// in tuser and tlast on the final chunk of the access.
// An access is pushed into the queue in the cycle it is taken. Its first
// chunk passes the queue, the back end's access registers and the output
// register. The back end loads a queued access only while idle, then emits
// one chunk per cycle while the receiver is ready, until the last chunk.
// When the receiver stalls, the output word holds and the queue fills; once
// it is full, s_axis_tready falls. Reset empties the queue, drops any
// partial access and clears the sequence number to zero.
// ----------------------------------------------------------------------------
module line_boundary_access_splitter_top #(
  parameter int QUEUE_DEPTH = lbas_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [79:0]   s_axis_tdata,  // thread_id[7:0], address[71:8], byte_count[78:72]
  input  logic          s_axis_tuser,  // is_write
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [111:0]  m_axis_tdata,  // chunk_thread[7:0], chunk_address[71:8],
                                       // sequence_number[103:72], chunk_bytes[107:104]
  output logic          m_axis_tuser,  // chunk_write
  output logic          m_axis_tlast   // last_chunk
);
  import lbas_pkg::*;

  access_t q_in;
  access_t q_out;
  logic    q_push;
  logic    q_ready;
  logic    q_valid;
  logic    q_pop;
  chunk_t  chunk;

  lbas_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .thread_id     (s_axis_tdata[7:0]),
    .address       (s_axis_tdata[71:8]),
    .byte_count    (s_axis_tdata[78:72]),
    .is_write      (s_axis_tuser),
    .q_ready       (q_ready),
    .q_push        (q_push),
    .q_data        (q_in)
  );

  lbas_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  lbas_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_chunk (chunk)
  );

  assign m_axis_tdata = {4'b0000, chunk.bytes, chunk.seq, chunk.address, chunk.thread};
  assign m_axis_tuser = chunk.write;
  assign m_axis_tlast = chunk.last;

endmodule

### sv/lbas_checker.sv
// ----------------------------------------------------------------------------
// Line boundary access splitter checker
// Port-level checks on the chunk stream, bound to the top level.
// ----------------------------------------------------------------------------
module lbas_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         m_axis_tlast
);

  logic        seen;
  logic [31:0] prev_seq;
  logic [6:0]  chunk_end;

  assign chunk_end = {1'b0, m_axis_tdata[13:8]} + {3'b000, m_axis_tdata[107:104]};

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      seen     <= 1'b1;
      prev_seq <= m_axis_tdata[103:72];
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && seen |-> m_axis_tdata[103:72] == prev_seq + 32'd1)
    else $error("sequence number did not advance by one");

  a_size_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[107:104] == 4'd1 || m_axis_tdata[107:104] == 4'd2 ||
                       m_axis_tdata[107:104] == 4'd4 || m_axis_tdata[107:104] == 4'd8))
    else $error("chunk size is not 1, 2, 4 or 8");

  a_in_line: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> chunk_end <= 7'd64)
    else $error("chunk crosses a line boundary");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind line_boundary_access_splitter_top lbas_checker u_lbas_checker (.*);
